// ----- rtl/kvlt_pkg.sv -----
// Package for the key/value line tokenizer: constants, codes, state and result types.
// Shared helper functions for byte classification and lower-casing. No dependencies.
`timescale 1ns / 1ps

package kvlt_pkg;

  localparam int MAX_LINE   = 512;
  localparam int LINE_POS_W = $clog2(MAX_LINE + 1);
  localparam int CNT_W      = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_EOL   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_KEY     = 3'd1,
    PH_PRESEP  = 3'd2,
    PH_POSTSEP = 3'd3,
    PH_VALUE   = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic                  after_cr;
    logic [LINE_POS_W-1:0] line_pos;
    logic [CNT_W-1:0]      key_count;
    logic [CNT_W-1:0]      value_count;
    logic [CNT_W-1:0]      trimmed_count;
  } line_state_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic [7:0]       ch_out;
    logic [CNT_W-1:0] index;
    logic [1:0]       status;
    logic [CNT_W-1:0] key_length;
    logic [CNT_W-1:0] value_length;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_EQ) || (c == CH_COMMA);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_key_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || is_upper(c) ||
           ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_US);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return is_upper(c) ? c + CASE_OFS : c;
  endfunction

endpackage

// ----- rtl/kvlt_if.sv -----
// Valid/ready channel interfaces for input bytes and result words.
// Depends on kvlt_pkg for field widths.
`timescale 1ns / 1ps

interface kvlt_in_if import kvlt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface kvlt_out_if import kvlt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       ch_out;
  logic [CNT_W-1:0] index;
  logic [1:0]       status;
  logic [CNT_W-1:0] key_length;
  logic [CNT_W-1:0] value_length;

  modport source (output valid, output kind, output ch_out, output index, output status,
                  output key_length, output value_length, input ready);
  modport sink   (input valid, input kind, input ch_out, input index, input status,
                  input key_length, input value_length, output ready);
endinterface

// ----- rtl/kvlt_step.sv -----
// Per-byte tokenizer step: next line state and the optional result word.
// Purely combinational; depends on kvlt_pkg.
`timescale 1ns / 1ps

module kvlt_step import kvlt_pkg::*; (
  input  line_state_t state_i,
  input  logic [7:0]  ch_i,
  output line_state_t state_o,
  output result_t     res_o
);

  always_comb begin
    logic             term;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] vcnt;

    term    = (ch_i == CH_CR) || (ch_i == CH_LF) || (ch_i == CH_NUL);
    idx     = '0;
    vcnt    = '0;
    state_o = state_i;
    res_o   = '0;
    state_o.after_cr = 1'b0;

    if (term) begin
      if (!((ch_i == CH_LF) && state_i.after_cr)) begin
        res_o.valid      = 1'b1;
        res_o.kind       = KIND_EOL;
        res_o.key_length = state_i.key_count;
        if (state_i.line_pos == '0) begin
          res_o.status = ST_EMPTY;
        end else if ((state_i.phase == PH_POSTSEP) || (state_i.phase == PH_VALUE)) begin
          res_o.status       = ST_OK;
          res_o.value_length = state_i.trimmed_count;
        end else begin
          res_o.status = ST_ERROR;
        end
        state_o.phase         = PH_LEAD;
        state_o.line_pos      = '0;
        state_o.key_count     = '0;
        state_o.value_count   = '0;
        state_o.trimmed_count = '0;
        state_o.after_cr      = (ch_i == CH_CR);
      end
    end else if (state_i.line_pos < LINE_POS_W'(MAX_LINE)) begin
      state_o.line_pos = state_i.line_pos + 1'b1;
      unique case (state_i.phase)
        PH_LEAD, PH_KEY: begin
          if (!((state_i.phase == PH_LEAD) && is_blank(ch_i))) begin
            if (is_key_char(ch_i)) begin
              idx = state_i.key_count;
              if (state_i.key_count < CNT_MAX) begin
                state_o.key_count = state_i.key_count + 1'b1;
              end
              state_o.phase = PH_KEY;
              res_o.valid   = 1'b1;
              res_o.kind    = KIND_KEY;
              res_o.ch_out  = to_lower(ch_i);
              res_o.index   = idx;
            end else if ((state_i.phase == PH_KEY) && is_blank(ch_i)) begin
              state_o.phase = PH_PRESEP;
            end else if ((state_i.phase == PH_KEY) && is_sep(ch_i)) begin
              state_o.phase = PH_POSTSEP;
            end else begin
              state_o.phase = PH_ERROR;
            end
          end
        end
        PH_PRESEP: begin
          if (!is_blank(ch_i)) begin
            state_o.phase = is_sep(ch_i) ? PH_POSTSEP : PH_ERROR;
          end
        end
        PH_POSTSEP, PH_VALUE: begin
          if (!((state_i.phase == PH_POSTSEP) && is_blank(ch_i))) begin
            state_o.phase = PH_VALUE;
            idx  = state_i.value_count;
            vcnt = state_i.value_count;
            if (state_i.value_count < CNT_MAX) begin
              vcnt = state_i.value_count + 1'b1;
            end
            state_o.value_count = vcnt;
            if (!is_blank(ch_i)) begin
              state_o.trimmed_count = vcnt;
            end
            res_o.valid  = 1'b1;
            res_o.kind   = KIND_VALUE;
            res_o.ch_out = ch_i;
            res_o.index  = idx;
          end
        end
        default: begin
          state_o.phase = PH_ERROR;
        end
      endcase
    end
  end

endmodule

// ----- rtl/key_value_line_tokenizer_top.sv -----
// Key/value line tokenizer top level: line state register, step logic and result register.
// Depends on kvlt_pkg, kvlt_if and kvlt_step.
// Each result word is registered and shown on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the result register is empty
// or is being drained in the same cycle.
// Reset: synchronous, active low; clears the line state and the result valid flag.
`timescale 1ns / 1ps

module key_value_line_tokenizer_top import kvlt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  kvlt_in_if.sink           in_if,
  kvlt_out_if.source        out_if
);

  line_state_t state_r;
  line_state_t state_nxt;
  result_t     res_nxt;
  result_t     res_r;
  logic        out_valid_r;
  logic        accept;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  kvlt_step u_step (
    .state_i (state_r),
    .ch_i    (in_if.ch),
    .state_o (state_nxt),
    .res_o   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{phase: PH_LEAD, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (accept) begin
        out_valid_r <= res_nxt.valid;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_nxt.valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = res_r.kind;
  assign out_if.ch_out       = res_r.ch_out;
  assign out_if.index        = res_r.index;
  assign out_if.status       = res_r.status;
  assign out_if.key_length   = res_r.key_length;
  assign out_if.value_length = res_r.value_length;

endmodule

// ----- rtl/kvlt_checker.sv -----
// Port-level checks on the tokenizer's result channel, bound to the top level.
// Depends on kvlt_pkg and key_value_line_tokenizer_top.
`timescale 1ns / 1ps

module kvlt_checker import kvlt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_kind,
  input logic [7:0]       out_ch_out,
  input logic [CNT_W-1:0] out_index,
  input logic [1:0]       out_status,
  input logic [CNT_W-1:0] out_key_length,
  input logic [CNT_W-1:0] out_value_length
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_ch_out) &&
      $stable(out_index) && $stable(out_status))
    else $error("result word changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_KEY) || (out_kind == KIND_VALUE) || (out_kind == KIND_EOL))
    else $error("illegal result kind");

  a_eol_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EOL) |-> (out_ch_out == 8'h00) && (out_index == '0) &&
      ((out_status == ST_OK) || (out_status == ST_EMPTY) || (out_status == ST_ERROR)))
    else $error("end-of-line word carries byte fields");

  a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_EOL) |-> (out_status == ST_OK) &&
      (out_key_length == '0) && (out_value_length == '0))
    else $error("byte word carries line fields");

  a_vlen_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EOL) && (out_status != ST_OK) |-> (out_value_length == '0))
    else $error("value length on a failed or empty line");

endmodule

bind key_value_line_tokenizer_top kvlt_checker u_kvlt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_kind         (out_if.kind),
  .out_ch_out       (out_if.ch_out),
  .out_index        (out_if.index),
  .out_status       (out_if.status),
  .out_key_length   (out_if.key_length),
  .out_value_length (out_if.value_length)
);

// ----- test/kvlt_checker.sv -----
// Result checker for the key/value line tokenizer: watches the byte and result channels,
// predicts the expected words from the accepted bytes and compares them field by field.
// Depends on kvlt_pkg and the channel interfaces in kvlt_if.
`timescale 1ns / 1ps

module key_value_line_tokenizer_checker import kvlt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  kvlt_in_if   in_mon,
  kvlt_out_if  out_mon,
  output int   mismatches,
  output int   pending,
  output int   words_checked,
  output int   ok_lines,
  output int   empty_lines,
  output int   error_lines
);

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       ch_out;
    logic [CNT_W-1:0] index;
    logic [1:0]       status;
    logic [CNT_W-1:0] key_length;
    logic [CNT_W-1:0] value_length;
  } token_t;

  token_t expected_tokens[$];

  phase_t                line_phase = PH_LEAD;
  logic                  seen_cr    = 1'b0;
  logic [LINE_POS_W-1:0] line_pos   = '0;
  logic [CNT_W-1:0]      key_cnt    = '0;
  logic [CNT_W-1:0]      val_cnt    = '0;
  logic [CNT_W-1:0]      trim_cnt   = '0;

  int mismatch_total = 0;
  int checked_total  = 0;
  int ok_total       = 0;
  int empty_total    = 0;
  int error_total    = 0;

  initial begin
    mismatches    = 0;
    pending       = 0;
    words_checked = 0;
    ok_lines      = 0;
    empty_lines   = 0;
    error_lines   = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_total++;
    if (mismatch_total <= 40) begin
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  function automatic void start_line();
    line_phase = PH_LEAD;
    line_pos   = '0;
    key_cnt    = '0;
    val_cnt    = '0;
    trim_cnt   = '0;
  endfunction

  function automatic void tokenize_byte(input logic [7:0] c);
    token_t t;
    logic   prev_cr;
    logic   blank;
    logic   sep;
    logic   key_char;
    t        = '0;
    prev_cr  = seen_cr;
    seen_cr  = 1'b0;
    blank    = (c == CH_SPACE) || (c == CH_TAB);
    sep      = (c == CH_EQ) || (c == CH_COMMA);
    key_char = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) || (c == CH_US);
    if ((c == CH_CR) || (c == CH_LF) || (c == CH_NUL)) begin
      if ((c == CH_LF) && prev_cr) return;
      t.kind       = KIND_EOL;
      t.key_length = key_cnt;
      if (line_pos == 0) begin
        t.status = ST_EMPTY;
        empty_total++;
      end else if ((line_phase == PH_POSTSEP) || (line_phase == PH_VALUE)) begin
        t.status       = ST_OK;
        t.value_length = trim_cnt;
        ok_total++;
      end else begin
        t.status = ST_ERROR;
        error_total++;
      end
      expected_tokens.push_back(t);
      start_line();
      seen_cr = (c == CH_CR);
      return;
    end
    if (line_pos >= MAX_LINE) return;
    line_pos++;
    case (line_phase)
      PH_LEAD, PH_KEY: begin
        if ((line_phase == PH_LEAD) && blank) return;
        if (key_char) begin
          t.kind   = KIND_KEY;
          t.ch_out = (c inside {[8'h41:8'h5A]}) ? c + CASE_OFS : c;
          t.index  = key_cnt;
          if (key_cnt != CNT_MAX) key_cnt++;
          line_phase = PH_KEY;
          expected_tokens.push_back(t);
        end else if ((line_phase == PH_KEY) && blank) begin
          line_phase = PH_PRESEP;
        end else if ((line_phase == PH_KEY) && sep) begin
          line_phase = PH_POSTSEP;
        end else begin
          line_phase = PH_ERROR;
        end
      end
      PH_PRESEP: begin
        if (!blank) line_phase = sep ? PH_POSTSEP : PH_ERROR;
      end
      PH_POSTSEP, PH_VALUE: begin
        if (!((line_phase == PH_POSTSEP) && blank)) begin
          line_phase = PH_VALUE;
          t.kind     = KIND_VALUE;
          t.ch_out   = c;
          t.index    = val_cnt;
          if (val_cnt != CNT_MAX) val_cnt++;
          if (!blank) trim_cnt = val_cnt;
          expected_tokens.push_back(t);
        end
      end
      default: line_phase = PH_ERROR;
    endcase
  endfunction

  task automatic compare_word();
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("word with nothing expected, kind", out_mon.kind, -1);
      return;
    end
    want = expected_tokens.pop_front();
    checked_total++;
    if (out_mon.kind !== want.kind)
      report_mismatch("kind", out_mon.kind, want.kind);
    if (out_mon.ch_out !== want.ch_out)
      report_mismatch("ch_out", out_mon.ch_out, want.ch_out);
    if (out_mon.index !== want.index)
      report_mismatch("index", out_mon.index, want.index);
    if (out_mon.status !== want.status)
      report_mismatch("status", out_mon.status, want.status);
    if (out_mon.key_length !== want.key_length)
      report_mismatch("key_length", out_mon.key_length, want.key_length);
    if (out_mon.value_length !== want.value_length)
      report_mismatch("value_length", out_mon.value_length, want.value_length);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_line();
      seen_cr = 1'b0;
      expected_tokens.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) compare_word();
      if (in_mon.valid && in_mon.ready) tokenize_byte(in_mon.ch);
    end
    mismatches    <= mismatch_total;
    pending       <= expected_tokens.size();
    words_checked <= checked_total;
    ok_lines      <= ok_total;
    empty_lines   <= empty_total;
    error_lines   <= error_total;
  end

endmodule

// ----- test/key_value_line_tokenizer_top_test.sv -----
// Testbench top for the key/value line tokenizer: clock, reset, byte stimulus with random
// idling on both channels, and the final verdict. Depends on kvlt_pkg, kvlt_if, the block
// and key_value_line_tokenizer_checker, which does the prediction and comparison.
`timescale 1ns / 1ps

module key_value_line_tokenizer_top_test;
  import kvlt_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int RANDOM_BYTES = 400;

  logic clk   = 1'b0;
  logic rst_n;

  kvlt_in_if  in_if ();
  kvlt_out_if out_if ();

  key_value_line_tokenizer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  int mismatches;
  int pending;
  int words_checked;
  int ok_lines;
  int empty_lines;
  int error_lines;

  key_value_line_tokenizer_checker token_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked),
    .ok_lines      (ok_lines),
    .empty_lines   (empty_lines),
    .error_lines   (error_lines)
  );

  int in_gap_max   = 12;
  int out_gap_max  = 12;
  bit hold_request = 1'b0;
  int held_cycles  = 0;
  int bytes_sent   = 0;
  int lines_sent   = 0;

  logic [7:0] line_bytes[$];
  logic [7:0] directed_bytes[$] = {
    CH_TAB, 8'h4B, CH_US, 8'h39, CH_SPACE, CH_EQ, CH_TAB, 8'h76, CH_SPACE, 8'h78,
    CH_SPACE, CH_CR, CH_LF,
    CH_LF,
    CH_SPACE, CH_NUL,
    CH_COMMA, CH_CR,
    8'h7A, CH_COMMA, CH_LF,
    8'h61, 8'hFF, CH_LF,
    8'h61, CH_SPACE, 8'h63, CH_CR
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] random_key_char();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + (r - 26));
    if (r < 62) return 8'(8'h30 + (r - 52));
    return CH_US;
  endfunction

  function automatic logic [7:0] random_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] random_value_char();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h20, 8'h7E));
    do b = 8'($urandom_range(1, 255)); while ((b == CH_LF) || (b == CH_CR));
    return b;
  endfunction

  function automatic void add_blanks(input int most);
    repeat ($urandom_range(0, most)) line_bytes.push_back(random_blank());
  endfunction

  function automatic void add_terminator();
    case ($urandom_range(0, 3))
      0: line_bytes.push_back(CH_CR);
      1: line_bytes.push_back(CH_LF);
      2: line_bytes.push_back(CH_NUL);
      default: begin
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
      end
    endcase
  endfunction

  function automatic void build_pair_line(input int key_len, input int val_len);
    line_bytes.delete();
    add_blanks(2);
    repeat (key_len) line_bytes.push_back(random_key_char());
    add_blanks(2);
    line_bytes.push_back($urandom_range(0, 1) ? CH_EQ : CH_COMMA);
    add_blanks(2);
    repeat (val_len) line_bytes.push_back(random_value_char());
    add_blanks(2);
    add_terminator();
  endfunction

  function automatic void build_noise_line();
    line_bytes.delete();
    repeat ($urandom_range(0, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
    add_terminator();
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= b;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic send_line(input bit counted);
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    if (counted) bytes_sent += line_bytes.size();
    lines_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int gap;
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_cycles += HOLD_CYCLES;
      end else if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout after %0d cycles with no word moving", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int line_no;
    int pick;
    in_if.valid <= 1'b0;
    in_if.ch    <= '0;
    rst_n       <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    line_bytes = directed_bytes;
    send_line(1'b1);
    drain_results();

    line_no = 0;
    while (bytes_sent < RANDOM_BYTES + directed_bytes.size()) begin
      line_no++;
      case ($urandom_range(0, 3))
        0: begin in_gap_max = 0;  out_gap_max = 0;  end
        1: begin in_gap_max = 12; out_gap_max = 0;  end
        2: begin in_gap_max = 0;  out_gap_max = 12; end
        default: begin in_gap_max = 12; out_gap_max = 12; end
      endcase
      if (line_no == 8) hold_request = 1'b1;
      if (line_no inside {[8:10]}) in_gap_max = 0;
      if (line_no == 20) drain_results();
      if (line_no == 30) begin
        build_pair_line(MAX_LINE + 8, 1);
        line_bytes = line_bytes[line_bytes.size() - 4 - MAX_LINE : $];
        send_line(1'b0);
      end else if (line_no == 40) begin
        build_pair_line(2, MAX_LINE + 20);
        send_line(1'b0);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 8) build_pair_line($urandom_range(1, 8), $urandom_range(0, 10));
        else build_noise_line();
        if (pick == 7) line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
            8'($urandom_range(0, 255));
        send_line(1'b1);
      end
    end

    drain_results();
    $display("Run covered %0d lines, %0d counted bytes and %0d result words checked.",
             lines_sent, bytes_sent, words_checked);
    $display("Lines ended ok %0d, empty %0d, in error %0d; output held off for %0d cycles.",
             ok_lines, empty_lines, error_lines, held_cycles);
    if ((mismatches == 0) && (pending == 0)) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- key_value_line_tokenizer_top.f -----
rtl/kvlt_pkg.sv
rtl/kvlt_if.sv
rtl/kvlt_step.sv
rtl/key_value_line_tokenizer_top.sv
rtl/kvlt_checker.sv
test/kvlt_checker.sv
test/key_value_line_tokenizer_top_test.sv
